/* hdl/lfj_pkg.sv */
package lfj_pkg;

  // Sizing of the list storage.
  localparam int MAX_LISTS  = 4;
  localparam int LIST_DEPTH = 256;

  localparam int KEY_W     = 32;
  localparam int CFG_W     = 3;
  localparam int LIST_W    = $clog2(MAX_LISTS);
  localparam int CNT_W     = LIST_W + 1;
  localparam int POS_W     = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W     = $clog2(LIST_DEPTH);
  localparam int ADDR_W    = LIST_W + IDX_W;
  localparam int MEM_DEPTH = MAX_LISTS * (2 ** IDX_W);

  // Request codes.
  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_INIT = 2'd1;
  localparam logic [1:0] FN_NEXT = 2'd2;
  localparam logic [1:0] FN_SEEK = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [1:0]              list_sel;
    logic signed [KEY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] match_key;
    logic                    at_end;
  } out_item_t;

endpackage

/* hdl/leapfrog_sorted_intersection.sv */
// Leapfrog intersection of up to four sorted key lists.
// Input channel (in_valid/in_ready/in_data) takes one request per beat:
// a load appends a key to a list, init rewinds all lists and searches,
// next and seek move the current list and search. A load gives no result;
// init, next and seek give one beat on the output channel
// (out_valid/out_ready/out_data) with the common key or at_end set.
// cfg_data sets the number of lists taking part (taken on any cycle).
// Init checks for empty lists, then insertion-sorts the lists taking part
// by first key, one list at a time and one shifted entry per step, then searches.
// A search first fetches the previous list's key as its bound; every list
// advance then reads the key memory once, so a search runs longer the more
// keys the lists skip. The single registered read port of the key
// memory and the one shared key comparator set this pace.
// The block takes no new request until its result is in the output
// register; a stalled receiver holds only that register, and the next
// request is worked on meanwhile up to the point of handing it over.
// After reset all lists are empty, the count is four and the block is
// at end, so next and seek answer end until an init is done.
module leapfrog_sorted_intersection
  import lfj_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_SLD   = 4'd2;
  localparam logic [3:0] ST_SORT  = 4'd3;
  localparam logic [3:0] ST_CHECK = 4'd4;
  localparam logic [3:0] ST_WRAP  = 4'd5;
  localparam logic [3:0] ST_MAXRD = 4'd6;
  localparam logic [3:0] ST_LOOK  = 4'd7;
  localparam logic [3:0] ST_AWRAP = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  // What a key read in ST_LOOK is for.
  localparam logic [1:0] PH_CMP   = 2'd0;
  localparam logic [1:0] PH_SEEK  = 2'd1;
  localparam logic [1:0] PH_ASEEK = 2'd2;

  logic [3:0]        st_r, st_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [POS_W-1:0]  len_r [MAX_LISTS];
  logic [POS_W-1:0]  len_nxt [MAX_LISTS];
  logic [POS_W-1:0]  pos_r [MAX_LISTS];
  logic [POS_W-1:0]  pos_nxt [MAX_LISTS];
  logic [LIST_W-1:0] order_r [MAX_LISTS];
  logic [LIST_W-1:0] order_nxt [MAX_LISTS];
  key_t              first_key_r [MAX_LISTS];
  key_t              first_key_nxt [MAX_LISTS];
  key_t              last_key_r [MAX_LISTS];
  key_t              last_key_nxt [MAX_LISTS];
  logic [LIST_W-1:0] slot_r, slot_nxt;
  key_t              cur_key_r, cur_key_nxt;
  logic              end_r, end_nxt;
  logic [CFG_W-1:0]  count_r, count_nxt;
  key_t              maxk_r, maxk_nxt;
  logic [LIST_W-1:0] i_r, i_nxt;
  logic [LIST_W-1:0] j_r, j_nxt;
  logic [LIST_W-1:0] v_r, v_nxt;
  key_t              vkey_r, vkey_nxt;
  logic              seek_fn_r, seek_fn_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [CNT_W-1:0]  live_n;
  logic [MAX_LISTS-1:0] done_v;
  logic              any_done;
  logic              any_empty;
  logic              pos_over;
  logic [LIST_W-1:0] cur_list, prev_slot, prev_list, nxt_slot, nxt_list;
  logic [POS_W-1:0]  pos_inc;
  logic              slot_big;
  logic              sel_ok;
  logic [LIST_W-1:0] sel_l;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  key_t              rd_data;
  key_t              cmp_a, cmp_b;
  logic              cmp_lt, cmp_eq;

  function automatic logic [ADDR_W-1:0] key_addr(input logic [LIST_W-1:0] l,
                                                 input logic [POS_W-1:0] p);
    return {l, p[IDX_W-1:0]};
  endfunction

  lfj_key_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lfj_key_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective list count: zero acts as one, large values saturate.
  always_comb begin
    if (count_r == '0) begin
      live_n = CNT_W'(1);
    end else if (32'(count_r) > MAX_LISTS) begin
      live_n = CNT_W'(MAX_LISTS);
    end else begin
      live_n = CNT_W'(count_r);
    end
  end

  // Per-list status and the slot neighbors of the current slot.
  always_comb begin
    any_done  = 1'b0;
    any_empty = 1'b0;
    pos_over  = 1'b0;
    for (int k = 0; k < MAX_LISTS; k++) begin
      done_v[k] = (pos_r[k] >= len_r[k]);
      pos_over  = pos_over | (pos_r[k] > len_r[k]);
    end
    for (int k = 0; k < MAX_LISTS; k++) begin
      if (CNT_W'(k) < live_n) begin
        any_done  = any_done | done_v[order_r[k]];
        any_empty = any_empty | (len_r[k] == '0);
      end
    end
    cur_list  = order_r[slot_r];
    prev_slot = (slot_r == '0) ? LIST_W'(live_n - CNT_W'(1)) : slot_r - LIST_W'(1);
    prev_list = order_r[prev_slot];
    nxt_slot  = (CNT_W'(slot_r) + CNT_W'(1) == live_n) ? '0 : slot_r + LIST_W'(1);
    nxt_list  = order_r[nxt_slot];
    pos_inc   = pos_r[cur_list] + POS_W'(1);
    slot_big  = (CNT_W'(slot_r) >= live_n);
    sel_ok    = (32'(in_data.list_sel) < MAX_LISTS);
    sel_l     = LIST_W'(in_data.list_sel);
  end

  // Operands of the shared comparator.
  always_comb begin
    unique case (st_r)
      ST_IDLE: begin
        cmp_a = last_key_r[sel_l];
        cmp_b = in_data.value;
      end
      ST_SORT: begin
        cmp_a = vkey_r;
        cmp_b = first_key_r[order_r[j_r - LIST_W'(1)]];
      end
      default: begin
        cmp_a = rd_data;
        cmp_b = maxk_r;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    order_nxt     = order_r;
    first_key_nxt = first_key_r;
    last_key_nxt  = last_key_r;
    slot_nxt      = slot_r;
    cur_key_nxt   = cur_key_r;
    end_nxt       = end_r;
    count_nxt     = count_r;
    maxk_nxt      = maxk_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    v_nxt         = v_r;
    vkey_nxt      = vkey_r;
    seek_fn_nxt   = seek_fn_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = key_addr(sel_l, len_r[sel_l]);
    rd_en         = 1'b0;
    rd_addr       = key_addr(cur_list, pos_r[cur_list]);

    if (cfg_valid) begin
      count_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FN_LOAD: begin
              // Append only keys above the list's last one, while room remains.
              if (sel_ok && (32'(len_r[sel_l]) < LIST_DEPTH) &&
                  ((len_r[sel_l] == '0) || cmp_lt)) begin
                wr_en                = 1'b1;
                len_nxt[sel_l]       = len_r[sel_l] + POS_W'(1);
                last_key_nxt[sel_l]  = in_data.value;
                if (len_r[sel_l] == '0) begin
                  first_key_nxt[sel_l] = in_data.value;
                end
              end
            end
            FN_INIT: begin
              for (int k = 0; k < MAX_LISTS; k++) begin
                pos_nxt[k]   = '0;
                order_nxt[k] = LIST_W'(k);
              end
              end_nxt = 1'b0;
              st_nxt  = ST_INIT;
            end
            default: begin
              seek_fn_nxt = (in_data.func == FN_SEEK);
              maxk_nxt    = in_data.value;
              st_nxt      = end_r ? ST_EMIT : ST_AWRAP;
            end
          endcase
        end
      end
      ST_INIT: begin
        if (any_empty) begin
          end_nxt = 1'b1;
          st_nxt  = ST_EMIT;
        end else if (live_n == CNT_W'(1)) begin
          slot_nxt = '0;
          st_nxt   = ST_CHECK;
        end else begin
          i_nxt  = LIST_W'(1);
          st_nxt = ST_SLD;
        end
      end
      ST_SLD: begin
        v_nxt    = order_r[i_r];
        vkey_nxt = first_key_r[order_r[i_r]];
        j_nxt    = i_r;
        st_nxt   = ST_SORT;
      end
      ST_SORT: begin
        // One insertion step: shift the larger entry up, or drop the held one in.
        if ((j_r != '0) && cmp_lt) begin
          order_nxt[j_r] = order_r[j_r - LIST_W'(1)];
          j_nxt          = j_r - LIST_W'(1);
        end else begin
          order_nxt[j_r] = v_r;
          if (CNT_W'(i_r) + CNT_W'(1) < live_n) begin
            i_nxt  = i_r + LIST_W'(1);
            st_nxt = ST_SLD;
          end else begin
            slot_nxt = '0;
            st_nxt   = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (any_done) begin
          end_nxt = 1'b1;
          st_nxt  = ST_EMIT;
        end else begin
          st_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        // Bring the slot below the count, then fetch the previous list's key.
        if (slot_big) begin
          slot_nxt = LIST_W'(CNT_W'(slot_r) - live_n);
        end else begin
          rd_en   = 1'b1;
          rd_addr = key_addr(prev_list, pos_r[prev_list]);
          st_nxt  = ST_MAXRD;
        end
      end
      ST_MAXRD: begin
        maxk_nxt  = rd_data;
        rd_en     = 1'b1;
        rd_addr   = key_addr(cur_list, pos_r[cur_list]);
        phase_nxt = PH_CMP;
        st_nxt    = ST_LOOK;
      end
      ST_LOOK: begin
        if ((phase_r == PH_CMP) && cmp_eq) begin
          cur_key_nxt = rd_data;
          st_nxt      = ST_EMIT;
        end else if (cmp_lt) begin
          // Key below the bound: step the current list on by one.
          pos_nxt[cur_list] = pos_inc;
          if (pos_inc >= len_r[cur_list]) begin
            end_nxt = 1'b1;
            st_nxt  = ST_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = key_addr(cur_list, pos_inc);
            if (phase_r == PH_CMP) begin
              phase_nxt = PH_SEEK;
            end
          end
        end else if (phase_r == PH_ASEEK) begin
          slot_nxt = nxt_slot;
          st_nxt   = ST_CHECK;
        end else begin
          // This list now holds the largest key; move on to the next slot.
          maxk_nxt  = rd_data;
          slot_nxt  = nxt_slot;
          rd_en     = 1'b1;
          rd_addr   = key_addr(nxt_list, pos_r[nxt_list]);
          phase_nxt = PH_CMP;
        end
      end
      ST_AWRAP: begin
        if (slot_big) begin
          slot_nxt = LIST_W'(CNT_W'(slot_r) - live_n);
        end else if (done_v[cur_list]) begin
          end_nxt = 1'b1;
          st_nxt  = ST_EMIT;
        end else if (seek_fn_r) begin
          rd_en     = 1'b1;
          rd_addr   = key_addr(cur_list, pos_r[cur_list]);
          phase_nxt = PH_ASEEK;
          st_nxt    = ST_LOOK;
        end else begin
          pos_nxt[cur_list] = pos_inc;
          if (pos_inc >= len_r[cur_list]) begin
            end_nxt = 1'b1;
            st_nxt  = ST_EMIT;
          end else begin
            slot_nxt = nxt_slot;
            st_nxt   = ST_CHECK;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.at_end    = end_r;
          out_data_nxt.match_key = end_r ? key_t'(0) : cur_key_r;
          st_nxt                 = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= PH_CMP;
      slot_r      <= '0;
      cur_key_r   <= '0;
      end_r       <= 1'b1;
      count_r     <= CFG_W'(4);
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_LISTS; k++) begin
        len_r[k]   <= '0;
        pos_r[k]   <= '0;
        order_r[k] <= LIST_W'(k);
      end
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      cur_key_r   <= cur_key_nxt;
      end_r       <= end_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      order_r     <= order_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    first_key_r <= first_key_nxt;
    last_key_r  <= last_key_nxt;
    maxk_r      <= maxk_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    v_r         <= v_nxt;
    vkey_r      <= vkey_nxt;
    seek_fn_r   <= seek_fn_nxt;
    out_data_r  <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // No read position ever passes its list's length.
  assert property (@(posedge clk) disable iff (!rst_n) !pos_over)
    else $error("list position beyond list length");

  // A result with end set always carries a zero key.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.at_end) |-> (out_data.match_key == key_t'(0)))
    else $error("end result with nonzero key");

  // A new result beat only follows the hand-over state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(st_r) == ST_EMIT))
    else $error("result raised outside hand-over");
`endif

endmodule

/* hdl/lfj_key_mem.sv */
module lfj_key_mem
  import lfj_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  key_t              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output key_t              rd_data
);

  key_t mem [MEM_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/lfj_key_cmp.sv */
module lfj_key_cmp
  import lfj_pkg::*;
(
  input  key_t a,
  input  key_t b,
  output logic lt,
  output logic eq
);

  // Signed key ordering shared by loads, the init sort and the search.
  assign lt = (a < b);
  assign eq = (a == b);

endmodule

/* sim/lfj_join_checker.sv */
`timescale 1ns / 100ps

module lfj_join_checker
  import lfj_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               answers_due
);

  // Shadow copy of the key lists and of the join state.
  key_t              keys   [MAX_LISTS][LIST_DEPTH];
  logic [POS_W-1:0]  fill   [MAX_LISTS];
  logic [POS_W-1:0]  cursor [MAX_LISTS];
  logic [LIST_W-1:0] order  [MAX_LISTS];
  logic [LIST_W-1:0] slot;
  key_t              join_key;
  logic              join_done;
  logic [CFG_W-1:0]  list_cfg;

  // Answers still owed by the block, oldest first.
  out_item_t answer_q [$];
  out_item_t oldest;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_model();
    int l;
    int d;
    for (l = 0; l < MAX_LISTS; l++) begin
      fill[l]   = '0;
      cursor[l] = '0;
      order[l]  = LIST_W'(l);
      for (d = 0; d < LIST_DEPTH; d++) keys[l][d] = '0;
    end
    slot      = '0;
    join_key  = '0;
    join_done = 1'b1;
    list_cfg  = CFG_W'(MAX_LISTS);
  endfunction

  // A count of zero behaves as one, anything above the list total as the total.
  function automatic int active_lists();
    int c;
    c = int'(list_cfg);
    if (c == 0) c = 1;
    if (c > MAX_LISTS) c = MAX_LISTS;
    return c;
  endfunction

  function automatic logic exhausted(int l);
    return cursor[l] >= fill[l];
  endfunction

  function automatic key_t head_key(int l);
    if (cursor[l] >= LIST_DEPTH) return '0;
    return keys[l][cursor[l]];
  endfunction

  function automatic int list_in_slot(int s);
    return int'(order[s % MAX_LISTS]);
  endfunction

  function automatic void skip_below(int l, key_t target);
    while (!exhausted(l) && head_key(l) < target) cursor[l] = cursor[l] + 1'b1;
  endfunction

  // Leapfrog: move each list in turn up to the largest key seen so far until
  // all heads agree, or give up as soon as one list runs dry.
  function automatic void leapfrog_search();
    int   n;
    int   s;
    int   l;
    key_t top;
    logic agreed;
    n = active_lists();
    for (s = 0; s < n; s++) begin
      if (exhausted(list_in_slot(s))) begin
        join_done = 1'b1;
        return;
      end
    end
    slot   = LIST_W'(int'(slot) % n);
    top    = head_key(list_in_slot((int'(slot) + n - 1) % n));
    agreed = 1'b0;
    while (!agreed) begin
      l = list_in_slot(int'(slot));
      if (head_key(l) == top) begin
        join_key = top;
        agreed   = 1'b1;
      end else begin
        skip_below(l, top);
        if (exhausted(l)) begin
          join_done = 1'b1;
          return;
        end
        top  = head_key(l);
        slot = LIST_W'((int'(slot) + 1) % n);
      end
    end
  endfunction

  // Rewind, stable insertion sort of the lists by first key, then search.
  function automatic void join_init();
    int                n;
    int                i;
    int                j;
    logic [LIST_W-1:0] v;
    n = active_lists();
    join_done = 1'b0;
    for (i = 0; i < MAX_LISTS; i++) begin
      cursor[i] = '0;
      order[i]  = LIST_W'(i);
    end
    for (i = 0; i < n; i++) begin
      if (fill[i] == '0) begin
        join_done = 1'b1;
        return;
      end
    end
    for (i = 1; i < n; i++) begin
      v = order[i];
      j = i;
      while (j > 0 && head_key(int'(v)) < head_key(int'(order[j-1]))) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    slot = '0;
    leapfrog_search();
  endfunction

  function automatic void join_advance(logic by_seek, key_t target);
    int n;
    int l;
    n    = active_lists();
    slot = LIST_W'(int'(slot) % n);
    l    = list_in_slot(int'(slot));
    if (exhausted(l)) begin
      join_done = 1'b1;
      return;
    end
    if (by_seek) skip_below(l, target);
    else cursor[l] = cursor[l] + 1'b1;
    if (exhausted(l)) begin
      join_done = 1'b1;
      return;
    end
    slot = LIST_W'((int'(slot) + 1) % n);
    leapfrog_search();
  endfunction

  function automatic void take_request(in_item_t req);
    int        l;
    out_item_t ans;
    l = int'(req.list_sel);
    case (req.func)
      FN_LOAD: begin
        // Only strictly ascending keys into a list with room are kept.
        if (l < MAX_LISTS && fill[l] < LIST_DEPTH &&
            (fill[l] == '0 || keys[l][fill[l] - 1'b1] < req.value)) begin
          keys[l][fill[l]] = req.value;
          fill[l] = fill[l] + 1'b1;
        end
      end
      FN_INIT: join_init();
      default: begin
        if (!join_done) join_advance(req.func == FN_SEEK, req.value);
      end
    endcase
    if (req.func != FN_LOAD) begin
      ans.match_key = join_done ? key_t'(0) : join_key;
      ans.at_end    = join_done;
      answer_q.push_back(ans);
    end
  endfunction

  // Result beats are checked before the request of the same edge is taken,
  // since that request's answer cannot leave on the edge it arrives.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      answer_q.delete();
      fail_count  = 0;
      answers_due = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed: key %0d end %0b",
                                    out_data.match_key, out_data.at_end));
        end else begin
          oldest = answer_q.pop_front();
          if (out_data.match_key !== oldest.match_key)
            report_mismatch($sformatf("match_key %0d, predicted %0d",
                                      out_data.match_key, oldest.match_key));
          if (out_data.at_end !== oldest.at_end)
            report_mismatch($sformatf("at_end %0b, predicted %0b",
                                      out_data.at_end, oldest.at_end));
        end
      end
      if (cfg_valid && cfg_ready) list_cfg = cfg_data;
      if (in_valid && in_ready) take_request(in_data);
      answers_due = answer_q.size();
    end
  end

endmodule

/* sim/tb_leapfrog_sorted_intersection.sv */
`timescale 1ns / 100ps

module tb_leapfrog_sorted_intersection;
  import lfj_pkg::*;

  localparam int   STALL_LIMIT = 20000;
  localparam int   SETTLE      = 8;
  localparam int   BAND_W      = 28;
  localparam key_t KEY_LO      = key_t'(32'h8000_0000);
  localparam key_t KEY_HI      = key_t'(32'h7FFF_FFFF);

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_e;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int   fail_count;
  int   answers_due;
  int   items_sent    = 0;
  int   burst_left    = 0;
  int   quiet_cycles  = 0;
  logic steady_sender = 1'b0;

  // Keys of the current band, ascending; lists draw subsets of them.
  key_t band_keys [16];
  int   band_size;
  int   band_stride;

  leapfrog_sorted_intersection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lfj_join_checker u_join_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver stalls follow their own pattern, switching mode every so often.
  initial begin
    rx_mode_e mode;
    int       span;
    out_ready <= 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
          default:   out_ready <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  // One request beat; bursts of random length, with random gaps between them unless the sender is steady.
  task automatic send_request(input logic [1:0] fn, input logic [1:0] sel, input key_t val);
    int       gap;
    in_item_t item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = steady_sender ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item.func     = fn;
    item.list_sel = sel;
    item.value    = val;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Let every owed answer out, then give a trailing load time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (answers_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_count(input logic [CFG_W-1:0] c);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint band_base(int band);
    return -64'sd2147483648 + (longint'(band) <<< BAND_W);
  endfunction

  // Seek targets: on a band key, just off one, or anywhere at all.
  function automatic key_t aim_key();
    int   r;
    key_t k;
    r = $urandom_range(0, band_size - 1);
    k = band_keys[r];
    case ($urandom_range(0, 3))
      0:       return k;
      1:       return k - 1;
      2:       return k + 1;
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] any_sel();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic directed_round();
    // Nothing has been initialized yet, and then every list is empty.
    send_request(FN_NEXT, 2'd0, KEY_LO);
    send_request(FN_SEEK, 2'd3, KEY_HI);
    send_request(FN_INIT, 2'd1, '0);
    // Repeated and falling keys are dropped by the list.
    send_request(FN_LOAD, 2'd0, KEY_LO);
    send_request(FN_LOAD, 2'd0, KEY_LO);
    send_request(FN_LOAD, 2'd0, KEY_LO + 100);
    send_request(FN_LOAD, 2'd0, KEY_LO + 50);
    send_request(FN_LOAD, 2'd1, KEY_LO + 100);
    send_request(FN_LOAD, 2'd1, KEY_LO);
    send_request(FN_LOAD, 2'd2, KEY_LO);
    send_request(FN_LOAD, 2'd2, KEY_LO + 100);
    send_request(FN_LOAD, 2'd3, KEY_LO + 100);
    // Lists 0 and 2 tie on their first key; the join meets at one key only.
    send_request(FN_INIT, 2'd2, KEY_HI);
    send_request(FN_NEXT, 2'd3, KEY_HI);
    send_request(FN_NEXT, 2'd0, '0);
    send_request(FN_SEEK, 2'd1, KEY_LO);
    send_request(FN_INIT, 2'd0, '0);
    // A target under the current key leaves the list where it is.
    send_request(FN_SEEK, 2'd2, KEY_LO);
    send_request(FN_SEEK, 2'd3, KEY_HI);
    // Zero lists behaves as one, seven as four.
    write_count(3'd0);
    send_request(FN_INIT, 2'd0, '0);
    send_request(FN_NEXT, 2'd0, '0);
    send_request(FN_NEXT, 2'd0, '0);
    write_count(3'd7);
    send_request(FN_INIT, 2'd3, KEY_HI);
    // Shrinking the count after init wraps the current slot.
    write_count(3'd2);
    send_request(FN_NEXT, 2'd1, KEY_LO);
    write_count(3'd1);
    send_request(FN_SEEK, 2'd1, KEY_LO + 100);
    write_count(3'd4);
  endtask

  // One band of keys: fill the lists with subsets, then walk the join.
  task automatic random_round(input int band);
    key_t   feed [MAX_LISTS][$];
    key_t   late;
    longint base;
    int     keep;
    int     left;
    int     l;
    int     u;
    int     pick;
    steady_sender = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 7) write_count(CFG_W'($urandom_range(0, 7)));
    base = band_base(band) + longint'($urandom_range(0, 1 << 26));
    case ($urandom_range(0, 2))
      0:       band_stride = 1;
      1:       band_stride = $urandom_range(2, 300);
      default: band_stride = $urandom_range(301, 1 << 20);
    endcase
    band_size = $urandom_range(3, 16);
    for (u = 0; u < band_size; u++) band_keys[u] = key_t'(base + longint'(u) * band_stride);
    left = 0;
    for (l = 0; l < MAX_LISTS; l++) begin
      keep = $urandom_range(30, 100);
      for (u = 0; u < band_size; u++) begin
        if ($urandom_range(1, 100) <= keep) begin
          feed[l].push_back(band_keys[u]);
          left++;
        end
      end
    end
    // Interleave the lists' loads, with the odd out-of-order key thrown in.
    while (left > 0) begin
      l = $urandom_range(0, MAX_LISTS - 1);
      if (feed[l].size() != 0) begin
        if ($urandom_range(0, 11) == 0)
          send_request(FN_LOAD, 2'(l), key_t'(base - longint'($urandom_range(1, 1000))));
        send_request(FN_LOAD, 2'(l), feed[l].pop_front());
        left--;
      end
    end
    send_request(FN_INIT, any_sel(), key_t'($urandom));
    late = band_keys[band_size - 1];
    repeat ($urandom_range(6, 24)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_request(FN_NEXT, any_sel(), key_t'($urandom));
      end else if (pick < 80) begin
        send_request(FN_SEEK, any_sel(), aim_key());
      end else if (pick < 87) begin
        send_request(FN_INIT, any_sel(), key_t'($urandom));
      end else if (pick < 95) begin
        // Keys appended while the join is under way.
        late = late + key_t'(band_stride);
        send_request(FN_LOAD, any_sel(), late);
      end else begin
        write_count(CFG_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Top band: overfill list 3 and put the largest key in the others.
  task automatic fill_round();
    longint k;
    int     l;
    steady_sender = 1'b1;
    k = band_base(15);
    repeat (LIST_DEPTH + 12) begin
      k = k + longint'($urandom_range(1, 4096));
      send_request(FN_LOAD, 2'd3, key_t'(k));
    end
    for (l = 0; l < MAX_LISTS; l++) send_request(FN_LOAD, 2'(l), KEY_HI);
    steady_sender = 1'b0;
    write_count(3'd3);
    send_request(FN_INIT, 2'd0, '0);
    send_request(FN_SEEK, 2'd2, KEY_HI - 1);
    send_request(FN_NEXT, 2'd1, KEY_LO);
    write_count(3'd4);
    send_request(FN_INIT, 2'd3, KEY_HI);
    send_request(FN_SEEK, 2'd0, KEY_HI);
    send_request(FN_NEXT, 2'd2, '0);
  endtask

  initial begin
    int band;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_round();
    band = 1;
    while (items_sent < 480 && band < 15) begin
      random_round(band);
      band++;
    end
    fill_round();

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
